// ===== hw/rtl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, wheel lane indexes and types for the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int IN_W          = 16;
    localparam int SUM_W         = 18;
    localparam int MAG_W         = 17;
    localparam int DUTY_W        = 8;
    localparam int DUTY_MAX_W    = 16;
    localparam int LANES         = 4;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DUTY_MAX_DEF  = 255;

    localparam int WHEEL_FL      = 0;
    localparam int WHEEL_FR      = 1;
    localparam int WHEEL_BL      = 2;
    localparam int WHEEL_BR      = 3;

    typedef logic signed [IN_W-1:0]  t_vel;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic        [MAG_W-1:0] t_mag;
    typedef logic        [DUTY_W-1:0] t_duty;

endpackage

// ===== hw/rtl/mwm_if.sv =====
// ----------------------------------------------------------------------------
// mwm_cmd_if / mwm_whl_if
// Valid/ready channels: chassis velocity command in, wheel drive result out.
// ----------------------------------------------------------------------------
interface mwm_cmd_if;
    logic          valid;
    logic          ready;
    mwm_pkg::t_vel vel_forward;
    mwm_pkg::t_vel vel_sideways;
    mwm_pkg::t_vel turn_rate;

    modport source (output valid, output vel_forward, output vel_sideways,
                    output turn_rate, input ready);
    modport sink   (input valid, input vel_forward, input vel_sideways,
                    input turn_rate, output ready);
endinterface

interface mwm_whl_if;
    logic           valid;
    logic           ready;
    mwm_pkg::t_duty duty_front_left;
    logic           fwd_front_left;
    mwm_pkg::t_duty duty_front_right;
    logic           fwd_front_right;
    mwm_pkg::t_duty duty_back_left;
    logic           fwd_back_left;
    mwm_pkg::t_duty duty_back_right;
    logic           fwd_back_right;

    modport source (output valid, output duty_front_left, output fwd_front_left,
                    output duty_front_right, output fwd_front_right,
                    output duty_back_left, output fwd_back_left,
                    output duty_back_right, output fwd_back_right, input ready);
    modport sink   (input valid, input duty_front_left, input fwd_front_left,
                    input duty_front_right, input fwd_front_right,
                    input duty_back_left, input fwd_back_left,
                    input duty_back_right, input fwd_back_right, output ready);
endinterface

// ===== hw/rtl/mecanum_wheel_mixer_unit.sv =====
// Takes one chassis velocity command per cycle unless the output stalls, and
// returns direction and PWM duty for all four mecanum wheels. Wheel speeds are
// vx-vy-w, vx+vy+w, vx+vy-w and vx-vy+w; when the largest magnitude exceeds
// 1.0 every wheel is scaled by it, truncating toward zero. The normalizing
// divider resolves one quotient bit per pipeline stage for the four wheels
// side by side; sustained rate is one transfer per cycle while the output
// accepts. Stages hold their own valid bits, so bubbles collapse and a new
// command is taken while a finished result waits on the output.
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_unit
// Mecanum inverse kinematics with peak normalization, fully pipelined.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_unit #(
    parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF,
    parameter int DUTY_MAX  = mwm_pkg::DUTY_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwm_cmd_if.sink     i_cmd,
    mwm_whl_if.source   o_whl
);

    localparam int LANES      = mwm_pkg::LANES;
    localparam int MAG_W      = mwm_pkg::MAG_W;
    localparam int SUM_W      = mwm_pkg::SUM_W;
    localparam int DUTY_W     = mwm_pkg::DUTY_W;
    localparam int DMW        = mwm_pkg::DUTY_MAX_W;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int DVS_W      = (QUO_W > MAG_W) ? QUO_W : MAG_W;
    localparam int STG_DIV0   = 3;
    localparam int NUM_STAGES = DIV_STAGES + 4;
    localparam int STG_OUT    = NUM_STAGES - 1;
    localparam int PROD_W     = QUO_W + DMW;

    localparam logic [DVS_W-1:0] ONE_Q  = {{(DVS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [DMW-1:0]   DUTY_K = DMW'(DUTY_MAX);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   en;

    mwm_pkg::t_sum vx, vy, wr;
    mwm_pkg::t_sum n_sum [LANES];
    mwm_pkg::t_sum r_sum [LANES];

    mwm_pkg::t_mag n_mag1 [LANES];
    mwm_pkg::t_mag r_mag1 [LANES];
    logic [LANES-1:0] n_fwd1, r_fwd1;

    mwm_pkg::t_mag     peak_a, peak_b, peak;
    logic [DVS_W-1:0]  n_dvs2, r_dvs2;
    logic [DVS_W-1:0]  r_mag2 [LANES];
    logic [LANES-1:0]  r_fwd2;

    logic [DVS_W-1:0]  r_rem [DIV_STAGES][LANES];
    logic [QUO_W-1:0]  r_quo [DIV_STAGES][LANES];
    logic [DVS_W-1:0]  r_dvs [DIV_STAGES];
    logic [LANES-1:0]  r_fwd [DIV_STAGES];

    logic [PROD_W-1:0] prod [LANES];
    mwm_pkg::t_duty    r_duty [LANES];
    logic [LANES-1:0]  r_fwdo;

    // stage enables: a stage loads when empty or when its successor moves on
    always_comb begin
        en[NUM_STAGES] = o_whl.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld = {r_vld[NUM_STAGES-2:0], i_cmd.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_cmd.ready = en[0];

    // stage 0: wheel sums
    always_comb begin
        vx = mwm_pkg::t_sum'(i_cmd.vel_forward);
        vy = mwm_pkg::t_sum'(i_cmd.vel_sideways);
        wr = mwm_pkg::t_sum'(i_cmd.turn_rate);
        n_sum[mwm_pkg::WHEEL_FL] = vx - vy - wr;
        n_sum[mwm_pkg::WHEEL_FR] = vx + vy + wr;
        n_sum[mwm_pkg::WHEEL_BL] = vx + vy - wr;
        n_sum[mwm_pkg::WHEEL_BR] = vx - vy + wr;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sum <= n_sum;
        end
    end

    // stage 1: magnitudes and direction
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_mag1[i] = r_sum[i][SUM_W-1] ? mwm_pkg::t_mag'(-r_sum[i])
                                          : mwm_pkg::t_mag'(r_sum[i]);
            n_fwd1[i] = !r_sum[i][SUM_W-1] && (r_sum[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_mag1 <= n_mag1;
            r_fwd1 <= n_fwd1;
        end
    end

    // stage 2: peak and divisor; divide by 1.0 when no scaling is needed
    always_comb begin
        peak_a = (r_mag1[0] > r_mag1[1]) ? r_mag1[0] : r_mag1[1];
        peak_b = (r_mag1[2] > r_mag1[3]) ? r_mag1[2] : r_mag1[3];
        peak   = (peak_a > peak_b) ? peak_a : peak_b;
        n_dvs2 = (DVS_W'(peak) > ONE_Q) ? DVS_W'(peak) : ONE_Q;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < LANES; i++) begin
                r_mag2[i] <= DVS_W'(r_mag1[i]);
            end
            r_dvs2 <= n_dvs2;
            r_fwd2 <= r_fwd1;
        end
    end

    // divider: one quotient bit per stage, integer bit first
    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        logic [DVS_W-1:0] rem_in [LANES];
        logic [QUO_W-1:0] quo_in [LANES];
        logic [DVS_W-1:0] dvs_in;
        logic [LANES-1:0] fwd_in;
        logic [DVS_W-1:0] n_rem [LANES];
        logic [QUO_W-1:0] n_quo [LANES];

        if (d == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < LANES; i++) begin
                    rem_in[i] = r_mag2[i];
                    quo_in[i] = '0;
                end
                dvs_in = r_dvs2;
                fwd_in = r_fwd2;
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < LANES; i++) begin
                    rem_in[i] = r_rem[d-1][i];
                    quo_in[i] = r_quo[d-1][i];
                end
                dvs_in = r_dvs[d-1];
                fwd_in = r_fwd[d-1];
            end
        end

        always_comb begin
            logic [DVS_W:0] trial;
            logic [DVS_W:0] diff;
            logic           ge;
            for (int i = 0; i < LANES; i++) begin
                trial = (d == 0) ? {1'b0, rem_in[i]} : {rem_in[i], 1'b0};
                diff  = trial - {1'b0, dvs_in};
                ge    = (trial >= {1'b0, dvs_in});
                n_rem[i] = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                n_quo[i] = {quo_in[i][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[STG_DIV0 + d]) begin
                r_rem[d] <= n_rem;
                r_quo[d] <= n_quo;
                r_dvs[d] <= dvs_in;
                r_fwd[d] <= fwd_in;
            end
        end
    end

    // output stage: scale to duty
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            prod[i] = PROD_W'(r_quo[DIV_STAGES-1][i]) * PROD_W'(DUTY_K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_OUT]) begin
            for (int i = 0; i < LANES; i++) begin
                r_duty[i] <= prod[i][FRAC_BITS +: DUTY_W];
            end
            r_fwdo <= r_fwd[DIV_STAGES-1];
        end
    end

    assign o_whl.valid            = r_vld[STG_OUT];
    assign o_whl.duty_front_left  = r_duty[mwm_pkg::WHEEL_FL];
    assign o_whl.fwd_front_left   = r_fwdo[mwm_pkg::WHEEL_FL];
    assign o_whl.duty_front_right = r_duty[mwm_pkg::WHEEL_FR];
    assign o_whl.fwd_front_right  = r_fwdo[mwm_pkg::WHEEL_FR];
    assign o_whl.duty_back_left   = r_duty[mwm_pkg::WHEEL_BL];
    assign o_whl.fwd_back_left    = r_fwdo[mwm_pkg::WHEEL_BL];
    assign o_whl.duty_back_right  = r_duty[mwm_pkg::WHEEL_BR];
    assign o_whl.fwd_back_right   = r_fwdo[mwm_pkg::WHEEL_BR];

endmodule

// ===== hw/rtl/mwm_checker.sv =====
// ----------------------------------------------------------------------------
// mwm_checker
// Port-level checks on the mecanum wheel mixer, bound to the top level.
// ----------------------------------------------------------------------------
module mwm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cmd_ready,
    input logic           i_whl_valid,
    input logic           i_whl_ready,
    input mwm_pkg::t_duty i_duty_fl,
    input mwm_pkg::t_duty i_duty_fr,
    input mwm_pkg::t_duty i_duty_bl,
    input mwm_pkg::t_duty i_duty_br,
    input logic           i_fwd_fl,
    input logic           i_fwd_fr,
    input logic           i_fwd_bl,
    input logic           i_fwd_br
);

    // no result may appear in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_whl_valid)
        else $error("result valid right after reset");

    // input backpressure only when the output holds a stalled transfer
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ready |-> (i_whl_valid && !i_whl_ready))
        else $error("input stalled without output backpressure");

    // fl+fr equals bl+br, so both front positive forbids both back non-positive
    a_sum_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_whl_valid && i_fwd_fl && i_fwd_fr) |-> (i_fwd_bl || i_fwd_br))
        else $error("wheel direction pattern impossible for mecanum mix");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_whl_valid && !i_whl_ready) |=>
            (i_whl_valid && $stable(i_duty_fl) && $stable(i_duty_fr)
             && $stable(i_duty_bl) && $stable(i_duty_br)))
        else $error("stalled result changed");

endmodule

bind mecanum_wheel_mixer_unit mwm_checker u_mwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_whl_valid (o_whl.valid),
    .i_whl_ready (o_whl.ready),
    .i_duty_fl   (o_whl.duty_front_left),
    .i_duty_fr   (o_whl.duty_front_right),
    .i_duty_bl   (o_whl.duty_back_left),
    .i_duty_br   (o_whl.duty_back_right),
    .i_fwd_fl    (o_whl.fwd_front_left),
    .i_fwd_fr    (o_whl.fwd_front_right),
    .i_fwd_bl    (o_whl.fwd_back_left),
    .i_fwd_br    (o_whl.fwd_back_right)
);
